// ----- src/owtr_pkg.sv -----
package owtr_pkg;

  localparam int TIME_W = 20;
  localparam int ATT_W  = 8;
  localparam int TEMP_W = 16;
  localparam int CFG_W  = 20;
  localparam int CFG_IDX_W = 2;

  // bus timing in microseconds
  localparam logic [TIME_W-1:0] T_RST_LOW   = 20'd480;
  localparam logic [TIME_W-1:0] T_PRES_WAIT = 20'd70;
  localparam logic [TIME_W-1:0] T_RST_POST  = 20'd410;
  localparam logic [TIME_W-1:0] T_W1_LOW    = 20'd6;
  localparam logic [TIME_W-1:0] T_W1_HIGH   = 20'd64;
  localparam logic [TIME_W-1:0] T_W0_LOW    = 20'd60;
  localparam logic [TIME_W-1:0] T_W0_HIGH   = 20'd10;
  localparam logic [TIME_W-1:0] T_RD_LOW    = 20'd2;
  localparam logic [TIME_W-1:0] T_RD_REL    = 20'd11;
  localparam logic [TIME_W-1:0] T_RD_TAIL   = 20'd47;
  localparam logic [TIME_W-1:0] T_ONE       = 20'd1;

  localparam logic [7:0] CMD_ADDR_ALL = 8'hCC;
  localparam logic [7:0] CMD_CONVERT  = 8'h44;
  localparam logic [7:0] CMD_READ_SP  = 8'hBE;
  localparam logic [7:0] CRC_POLY     = 8'h8C;

  localparam logic [3:0] CMD_BYTES    = 4'd2;
  localparam logic [3:0] CRC_BYTE_IDX = 4'd8;

  localparam logic [TIME_W-1:0] CONVERT_WAIT_RST = 20'd750000;
  localparam logic [TIME_W-1:0] RETRY_WAIT_RST   = 20'd20000;
  localparam logic [ATT_W-1:0]  MAX_ATTEMPTS_RST = 8'd20;

  localparam logic [CFG_IDX_W-1:0] CFG_CONVERT_WAIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_WAIT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ATTEMPTS = 2'd2;

  typedef enum logic [4:0] {
    PH_IDLE    = 5'd0,
    PH_R1_LOW  = 5'd1,
    PH_R1_REL  = 5'd2,
    PH_R1_POST = 5'd3,
    PH_W1_LOW  = 5'd4,
    PH_W1_HIGH = 5'd5,
    PH_CONV    = 5'd6,
    PH_R2_LOW  = 5'd7,
    PH_R2_REL  = 5'd8,
    PH_R2_POST = 5'd9,
    PH_W2_LOW  = 5'd10,
    PH_W2_HIGH = 5'd11,
    PH_RD_LOW  = 5'd12,
    PH_RD_REL  = 5'd13,
    PH_RD_TAIL = 5'd14,
    PH_RETRY   = 5'd15
  } phase_t;

  typedef struct packed {
    logic [TIME_W-1:0] convert_wait_us;
    logic [TIME_W-1:0] retry_wait_us;
    logic [ATT_W-1:0]  max_attempts;
  } cfg_t;

  typedef struct packed {
    logic                     drive_low;
    logic                     busy_res;
    logic                     done_res;
    logic                     read_ok;
    logic signed [TEMP_W-1:0] temperature;
    logic                     have_value;
  } result_t;

  function automatic logic drives_low(input phase_t ph);
    return (ph == PH_R1_LOW) || (ph == PH_R2_LOW) || (ph == PH_W1_LOW) ||
           (ph == PH_W2_LOW) || (ph == PH_RD_LOW);
  endfunction

endpackage

// ----- src/owtr_in_if.sv -----
interface owtr_in_if;
  logic valid;
  logic ready;
  logic opcode;
  logic line_level;

  modport source(output valid, output opcode, output line_level, input ready);
  modport sink(input valid, input opcode, input line_level, output ready);
endinterface

// ----- src/owtr_out_if.sv -----
interface owtr_out_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 drive_low;
  logic                                 busy_res;
  logic                                 done_res;
  logic                                 read_ok;
  logic signed [owtr_pkg::TEMP_W-1:0]   temperature;
  logic                                 have_value;

  modport source(output valid, output drive_low, output busy_res, output done_res,
                 output read_ok, output temperature, output have_value, input ready);
  modport sink(input valid, input drive_low, input busy_res, input done_res,
               input read_ok, input temperature, input have_value, output ready);
endinterface

// ----- src/onewire_temperature_reader_top.sv -----
// channel   | dir | beat payload
// ----------+-----+----------------------------------------------------------
// items     | in  | opcode (tick / start), line_level
// results   | out | drive_low, busy_res, done_res, read_ok, temperature, have_value
// cfg       | in  | cfg_we, cfg_index, cfg_wdata (write only)
//
// One item per cycle unless stalled; its result is registered and shows in the next cycle.
// The sequencer state advances in the cycle an item is taken; one output register
// decouples the two sides.
// items.ready drops only while a result beat is held and results.ready is low.
// rst is synchronous: sequencer idle, config registers at their defaults, no result held.
module onewire_temperature_reader_top (
  input  logic                              clk,
  input  logic                              rst,
  owtr_in_if.sink                           items,
  owtr_out_if.source                        results,
  input  logic                              cfg_we,
  input  logic [owtr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [owtr_pkg::CFG_W-1:0]        cfg_wdata
);

  owtr_pkg::cfg_t    cfg;
  owtr_pkg::result_t res;
  owtr_pkg::result_t out_q;
  logic              out_vld;
  logic              accept;

  assign items.ready = ~out_vld | results.ready;
  assign accept      = items.valid & items.ready;

  owtr_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  owtr_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .opcode     (items.opcode),
    .line_level (items.line_level),
    .cfg        (cfg),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (accept) begin
      out_vld <= 1'b1;
    end else if (results.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_q <= res;
    end
  end

  assign results.valid       = out_vld;
  assign results.drive_low   = out_q.drive_low;
  assign results.busy_res    = out_q.busy_res;
  assign results.done_res    = out_q.done_res;
  assign results.read_ok     = out_q.read_ok;
  assign results.temperature = out_q.temperature;
  assign results.have_value  = out_q.have_value;

  a_ok_with_done: assert property (@(posedge clk) disable iff (rst)
    (out_vld && out_q.read_ok) |-> out_q.done_res)
    else $error("read_ok without done_res");

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    (out_vld && out_q.done_res) |-> !out_q.busy_res)
    else $error("done_res while still busy");

  a_ok_sets_value: assert property (@(posedge clk) disable iff (rst)
    (out_vld && out_q.read_ok) |-> out_q.have_value)
    else $error("good read without have_value");

endmodule

// ----- src/owtr_cfg_regs.sv -----
module owtr_cfg_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [owtr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [owtr_pkg::CFG_W-1:0]        cfg_wdata,
  output owtr_pkg::cfg_t                    cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.convert_wait_us <= owtr_pkg::CONVERT_WAIT_RST;
      cfg.retry_wait_us   <= owtr_pkg::RETRY_WAIT_RST;
      cfg.max_attempts    <= owtr_pkg::MAX_ATTEMPTS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        owtr_pkg::CFG_CONVERT_WAIT: cfg.convert_wait_us <= cfg_wdata[owtr_pkg::TIME_W-1:0];
        owtr_pkg::CFG_RETRY_WAIT:   cfg.retry_wait_us   <= cfg_wdata[owtr_pkg::TIME_W-1:0];
        owtr_pkg::CFG_MAX_ATTEMPTS: cfg.max_attempts    <= cfg_wdata[owtr_pkg::ATT_W-1:0];
        default: ;  // unmapped index, dropped
      endcase
    end
  end

endmodule

// ----- src/owtr_seq.sv -----
module owtr_seq (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic                 opcode,
  input  logic                 line_level,
  input  owtr_pkg::cfg_t       cfg,
  output owtr_pkg::result_t    res
);

  owtr_pkg::phase_t                      phase, phase_next;
  logic [owtr_pkg::TIME_W-1:0]           time_count, time_count_next;
  logic [2:0]                            bit_count, bit_count_next;
  logic [3:0]                            byte_count, byte_count_next;
  logic [7:0]                            shift_byte, shift_byte_next;
  logic [7:0]                            crc_accum, crc_accum_next;
  logic [owtr_pkg::TEMP_W-1:0]           raw_capture, raw_capture_next;
  logic [owtr_pkg::ATT_W-1:0]            attempt_count, attempt_count_next;
  logic signed [owtr_pkg::TEMP_W-1:0]    last_temperature, last_temperature_next;
  logic                                  valid_seen, valid_seen_next;
  logic                                  presence_ok, presence_ok_next;

  logic [7:0]                  cmd_byte;
  logic                        cmd_bit;
  logic [owtr_pkg::TIME_W-1:0] duration;
  logic [owtr_pkg::TIME_W-1:0] time_inc;
  logic                        done, ok, drive;

  // command byte being shifted out: skip-ROM first, then convert or read-scratchpad
  always_comb begin
    if (byte_count == 4'd0) begin
      cmd_byte = owtr_pkg::CMD_ADDR_ALL;
    end else if (phase == owtr_pkg::PH_W1_LOW || phase == owtr_pkg::PH_W1_HIGH) begin
      cmd_byte = owtr_pkg::CMD_CONVERT;
    end else begin
      cmd_byte = owtr_pkg::CMD_READ_SP;
    end
  end

  assign cmd_bit  = cmd_byte[bit_count];
  assign time_inc = time_count + owtr_pkg::T_ONE;

  always_comb begin
    unique case (phase)
      owtr_pkg::PH_R1_LOW, owtr_pkg::PH_R2_LOW:   duration = owtr_pkg::T_RST_LOW;
      owtr_pkg::PH_R1_REL, owtr_pkg::PH_R2_REL:   duration = owtr_pkg::T_PRES_WAIT;
      owtr_pkg::PH_R1_POST, owtr_pkg::PH_R2_POST: duration = owtr_pkg::T_RST_POST;
      owtr_pkg::PH_W1_LOW, owtr_pkg::PH_W2_LOW:
        duration = cmd_bit ? owtr_pkg::T_W1_LOW : owtr_pkg::T_W0_LOW;
      owtr_pkg::PH_W1_HIGH, owtr_pkg::PH_W2_HIGH:
        duration = cmd_bit ? owtr_pkg::T_W1_HIGH : owtr_pkg::T_W0_HIGH;
      owtr_pkg::PH_CONV:    duration = cfg.convert_wait_us;
      owtr_pkg::PH_RD_LOW:  duration = owtr_pkg::T_RD_LOW;
      owtr_pkg::PH_RD_REL:  duration = owtr_pkg::T_RD_REL;
      owtr_pkg::PH_RD_TAIL: duration = owtr_pkg::T_RD_TAIL;
      owtr_pkg::PH_RETRY:   duration = cfg.retry_wait_us;
      default:              duration = owtr_pkg::T_ONE;
    endcase
  end

  always_comb begin
    phase_next            = phase;
    time_count_next       = time_count;
    bit_count_next        = bit_count;
    byte_count_next       = byte_count;
    shift_byte_next       = shift_byte;
    crc_accum_next        = crc_accum;
    raw_capture_next      = raw_capture;
    attempt_count_next    = attempt_count;
    last_temperature_next = last_temperature;
    valid_seen_next       = valid_seen;
    presence_ok_next      = presence_ok;
    done                  = 1'b0;
    ok                    = 1'b0;
    drive                 = owtr_pkg::drives_low(phase);

    if (opcode) begin
      if (phase == owtr_pkg::PH_IDLE) begin
        phase_next         = owtr_pkg::PH_R1_LOW;
        time_count_next    = '0;
        attempt_count_next = '0;
        presence_ok_next   = 1'b0;
      end
      drive = owtr_pkg::drives_low(phase_next);
    end else if (phase != owtr_pkg::PH_IDLE) begin
      // line samples land on the first tick of the post-reset and read-tail phases
      if (time_count == '0) begin
        if (phase == owtr_pkg::PH_R1_POST || phase == owtr_pkg::PH_R2_POST) begin
          presence_ok_next = ~line_level;
        end else if (phase == owtr_pkg::PH_RD_TAIL) begin
          if (byte_count < owtr_pkg::CRC_BYTE_IDX) begin
            crc_accum_next = {1'b0, crc_accum[7:1]} ^
                             ((crc_accum[0] ^ line_level) ? owtr_pkg::CRC_POLY : 8'h00);
          end
          shift_byte_next = {line_level, shift_byte[7:1]};
        end
      end

      if (time_inc >= duration) begin
        time_count_next = '0;
        unique case (phase)
          owtr_pkg::PH_R1_LOW: phase_next = owtr_pkg::PH_R1_REL;
          owtr_pkg::PH_R1_REL: phase_next = owtr_pkg::PH_R1_POST;
          owtr_pkg::PH_R1_POST: begin
            if (presence_ok_next) begin
              phase_next      = owtr_pkg::PH_W1_LOW;
              bit_count_next  = '0;
              byte_count_next = '0;
            end else begin
              phase_next = owtr_pkg::PH_RETRY;
            end
          end
          owtr_pkg::PH_W1_LOW: phase_next = owtr_pkg::PH_W1_HIGH;
          owtr_pkg::PH_W1_HIGH: begin
            bit_count_next  = bit_count + 3'd1;
            byte_count_next = byte_count + {3'b000, (bit_count_next == 3'd0)};
            if (byte_count_next >= owtr_pkg::CMD_BYTES) begin
              phase_next = owtr_pkg::PH_CONV;
            end else begin
              phase_next = owtr_pkg::PH_W1_LOW;
            end
          end
          owtr_pkg::PH_CONV:   phase_next = owtr_pkg::PH_R2_LOW;
          owtr_pkg::PH_R2_LOW: phase_next = owtr_pkg::PH_R2_REL;
          owtr_pkg::PH_R2_REL: phase_next = owtr_pkg::PH_R2_POST;
          owtr_pkg::PH_R2_POST: begin
            if (presence_ok_next) begin
              phase_next      = owtr_pkg::PH_W2_LOW;
              bit_count_next  = '0;
              byte_count_next = '0;
            end else begin
              phase_next = owtr_pkg::PH_RETRY;
            end
          end
          owtr_pkg::PH_W2_LOW: phase_next = owtr_pkg::PH_W2_HIGH;
          owtr_pkg::PH_W2_HIGH: begin
            bit_count_next  = bit_count + 3'd1;
            byte_count_next = byte_count + {3'b000, (bit_count_next == 3'd0)};
            if (byte_count_next >= owtr_pkg::CMD_BYTES) begin
              phase_next      = owtr_pkg::PH_RD_LOW;
              bit_count_next  = '0;
              byte_count_next = '0;
              shift_byte_next = '0;
              crc_accum_next  = '0;
            end else begin
              phase_next = owtr_pkg::PH_W2_LOW;
            end
          end
          owtr_pkg::PH_RD_LOW: phase_next = owtr_pkg::PH_RD_REL;
          owtr_pkg::PH_RD_REL: phase_next = owtr_pkg::PH_RD_TAIL;
          owtr_pkg::PH_RD_TAIL: begin
            bit_count_next = bit_count + 3'd1;
            phase_next     = owtr_pkg::PH_RD_LOW;
            if (bit_count_next == 3'd0) begin
              if (byte_count >= owtr_pkg::CRC_BYTE_IDX) begin
                // ninth byte is the CRC of the first eight
                if (crc_accum_next == shift_byte_next) begin
                  last_temperature_next = raw_capture;
                  valid_seen_next       = 1'b1;
                  phase_next            = owtr_pkg::PH_IDLE;
                  done                  = 1'b1;
                  ok                    = 1'b1;
                end else begin
                  phase_next = owtr_pkg::PH_RETRY;
                end
              end else begin
                if (byte_count == 4'd0) begin
                  raw_capture_next[7:0] = shift_byte_next;
                end else if (byte_count == 4'd1) begin
                  raw_capture_next[15:8] = shift_byte_next;
                end
                byte_count_next = byte_count + 4'd1;
              end
            end
          end
          owtr_pkg::PH_RETRY: begin
            attempt_count_next = attempt_count + 8'd1;
            if (attempt_count_next >= cfg.max_attempts) begin
              phase_next = owtr_pkg::PH_IDLE;
              done       = 1'b1;
            end else begin
              phase_next = owtr_pkg::PH_R1_LOW;
            end
          end
          default: phase_next = owtr_pkg::PH_IDLE;
        endcase
      end else begin
        time_count_next = time_inc;
      end
    end
  end

  always_comb begin
    res.drive_low   = drive;
    res.busy_res    = (phase_next != owtr_pkg::PH_IDLE);
    res.done_res    = done;
    res.read_ok     = ok;
    res.temperature = last_temperature_next;
    res.have_value  = valid_seen_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= owtr_pkg::PH_IDLE;
      time_count       <= '0;
      bit_count        <= '0;
      byte_count       <= '0;
      shift_byte       <= '0;
      crc_accum        <= '0;
      attempt_count    <= '0;
      last_temperature <= '0;
      valid_seen       <= 1'b0;
      presence_ok      <= 1'b0;
    end else if (accept) begin
      phase            <= phase_next;
      time_count       <= time_count_next;
      bit_count        <= bit_count_next;
      byte_count       <= byte_count_next;
      shift_byte       <= shift_byte_next;
      crc_accum        <= crc_accum_next;
      attempt_count    <= attempt_count_next;
      last_temperature <= last_temperature_next;
      valid_seen       <= valid_seen_next;
      presence_ok      <= presence_ok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      raw_capture <= raw_capture_next;
    end
  end

endmodule
